// ----- design/mf3_pkg.sv -----
// Shared types, constants and compare helpers of the 3x3 median filter.
package mf3_pkg;

   localparam int MF3_MAX_WIDTH    = 1024;
   localparam int MF3_MIN_DIM      = 3;
   localparam int MF3_WIDTH_RESET  = 640;
   localparam int MF3_HEIGHT_RESET = 480;
   localparam int MF3_WIN_DIM      = 3;
   localparam int MF3_WIN_CELLS    = MF3_WIN_DIM * MF3_WIN_DIM;
   localparam int MF3_CSR_W        = 12;

   localparam int MF3_QDEPTH = 4;
   localparam int MF3_QCNT_W = $clog2(MF3_QDEPTH + 1);
   localparam int MF3_ODEPTH = 8;
   localparam int MF3_OCNT_W = $clog2(MF3_ODEPTH + 1);

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } mf3_csr_index_type;

   typedef logic [7:0] mf3_pixel_type;

   typedef struct packed {
      mf3_pixel_type pixel_value;
      logic          frame_start;
   } mf3_req_type;

   typedef struct packed {
      mf3_pixel_type median_value;
      logic [11:0]   out_row;
      logic [9:0]    out_col;
      logic          frame_end;
   } mf3_rsp_type;

   // One in-range pixel with its new window column, handed from front to back.
   typedef struct packed {
      mf3_pixel_type px;
      mf3_pixel_type up;
      mf3_pixel_type mid;
      logic          emit;
      logic [11:0]   out_row;
      logic [9:0]    out_col;
      logic          frame_end;
   } mf3_entry_type;

   typedef struct packed {
      mf3_pixel_type lo;
      mf3_pixel_type md;
      mf3_pixel_type hi;
   } mf3_trio_type;

   function automatic mf3_pixel_type mf3_min(input mf3_pixel_type a, input mf3_pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic mf3_pixel_type mf3_max(input mf3_pixel_type a, input mf3_pixel_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic mf3_pixel_type mf3_med3(input mf3_pixel_type a, input mf3_pixel_type b,
                                              input mf3_pixel_type c);
      return mf3_max(mf3_min(a, b), mf3_min(mf3_max(a, b), c));
   endfunction

   function automatic mf3_trio_type mf3_sort3(input mf3_pixel_type a, input mf3_pixel_type b,
                                              input mf3_pixel_type c);
      mf3_trio_type t;
      t.lo = mf3_min(mf3_min(a, b), c);
      t.hi = mf3_max(mf3_max(a, b), c);
      t.md = mf3_med3(a, b, c);
      return t;
   endfunction

endpackage

// ----- design/mf3_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/mf3_fifo.sv -----
// Small register-based queue with a fill count.
module mf3_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  logic [WIDTH-1:0]                   push_data,
   input  logic                               pop,
   output logic [WIDTH-1:0]                   pop_data,
   output logic [$clog2(DEPTH + 1)-1:0]       count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNTW'(push) - CNTW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign count    = count_ff;

endmodule

// ----- design/mf3_front.sv -----
// Front end: settings, position counters, line stores and item classification.
module mf3_front #(
   parameter int MAX_WIDTH = mf3_pkg::MF3_MAX_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  mf3_pkg::mf3_csr_index_type        csr_index,
   input  logic [mf3_pkg::MF3_CSR_W-1:0]     csr_wdata,
   input  logic                              req_push,
   output logic                              req_full,
   input  mf3_pkg::mf3_req_type              req_data,
   input  logic [mf3_pkg::MF3_QCNT_W-1:0]    q_count,
   output logic                              q_push,
   output mf3_pkg::mf3_entry_type            q_data
);
   import mf3_pkg::*;

   localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW  = (CW + 1 > 11) ? CW + 1 : 11;
   localparam int QOW = MF3_QCNT_W + 1;

   logic [10:0]   width_ff;
   logic [11:0]   height_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [11:0]   row_ff, row_in;

   logic          s2_valid_ff;
   mf3_pixel_type s2_px_ff;
   logic [CW-1:0] s2_col_ff;
   logic          s2_inrange_ff, s2_emit_ff, s2_fend_ff;
   logic [11:0]   s2_orow_ff;
   logic [9:0]    s2_ocol_ff;
   logic          byp_ff, byp_in;
   mf3_pixel_type byp_up_ff, byp_mid_ff;

   logic          accept;
   logic [QOW-1:0] occupancy;
   logic [WW-1:0] w_raw, w_use, col_w, col_p1, col_m1;
   logic [11:0]   h_use, row_cur;
   logic [12:0]   row_p1;
   logic [CW-1:0] col_cur;
   logic          inrange, emit, fend;
   mf3_pixel_type rd_up, rd_mid, up_eff, mid_eff;
   logic          wr_en;

   // An item is taken only when the queue has room for it and the one in flight.
   assign occupancy = {1'b0, q_count} + QOW'(s2_valid_ff);
   assign req_full  = (occupancy >= QOW'(MF3_QDEPTH));
   assign accept    = req_push && !req_full;

   always_comb begin
      w_raw = WW'(width_ff);
      if (w_raw < WW'(MF3_MIN_DIM)) begin
         w_use = WW'(MF3_MIN_DIM);
      end else if (w_raw > WW'(MAX_WIDTH)) begin
         w_use = WW'(MAX_WIDTH);
      end else begin
         w_use = w_raw;
      end
      h_use = (height_ff < 12'(MF3_MIN_DIM)) ? 12'(MF3_MIN_DIM) : height_ff;
   end

   always_comb begin
      col_cur = req_data.frame_start ? '0 : col_ff;
      row_cur = req_data.frame_start ? '0 : row_ff;
      col_w   = WW'(col_cur);
      col_p1  = col_w + 1'b1;
      col_m1  = col_w - 1'b1;
      row_p1  = {1'b0, row_cur} + 13'd1;
      inrange = (col_w < w_use) && (row_cur < h_use);
      emit    = inrange && (col_w >= WW'(2)) && (row_cur >= 12'd2);
      fend    = (row_cur == h_use - 1'b1) && (col_w == w_use - 1'b1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (col_p1 >= w_use) begin
            col_in = '0;
            row_in = (row_p1 >= {1'b0, h_use}) ? '0 : row_p1[11:0];
         end else begin
            col_in = col_p1[CW-1:0];
            row_in = row_cur;
         end
      end
   end

   // The item in flight writes its column in the same cycle the next item reads;
   // a read of that same column takes the new values from the bypass.
   assign up_eff  = byp_ff ? byp_up_ff  : rd_up;
   assign mid_eff = byp_ff ? byp_mid_ff : rd_mid;
   assign wr_en   = s2_valid_ff && s2_inrange_ff;
   assign byp_in  = accept && wr_en && (s2_col_ff == col_cur);

   mf3_ram #(.WIDTH($bits(mf3_pixel_type)), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s2_col_ff),
      .wr_data (mid_eff),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (rd_up)
   );

   mf3_ram #(.WIDTH($bits(mf3_pixel_type)), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s2_col_ff),
      .wr_data (s2_px_ff),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (rd_mid)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 11'(MF3_WIDTH_RESET);
         height_ff   <= 12'(MF3_HEIGHT_RESET);
         col_ff      <= '0;
         row_ff      <= '0;
         s2_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH: begin
                  width_ff <= csr_wdata[10:0];
               end
               CSR_IMAGE_HEIGHT: begin
                  height_ff <= csr_wdata[11:0];
               end
               default: begin
               end
            endcase
         end
         col_ff      <= col_in;
         row_ff      <= row_in;
         s2_valid_ff <= accept;
         byp_ff      <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_px_ff      <= req_data.pixel_value;
         s2_col_ff     <= col_cur;
         s2_inrange_ff <= inrange;
         s2_emit_ff    <= emit;
         s2_orow_ff    <= row_cur - 1'b1;
         s2_ocol_ff    <= col_m1[9:0];
         s2_fend_ff    <= fend;
      end
      if (byp_in) begin
         byp_up_ff  <= mid_eff;
         byp_mid_ff <= s2_px_ff;
      end
   end

   assign q_push            = wr_en;
   assign q_data.px         = s2_px_ff;
   assign q_data.up         = up_eff;
   assign q_data.mid        = mid_eff;
   assign q_data.emit       = s2_emit_ff;
   assign q_data.out_row    = s2_orow_ff;
   assign q_data.out_col    = s2_ocol_ff;
   assign q_data.frame_end  = s2_fend_ff;

   ap_bypass_live: assert property (@(posedge clock) disable iff (reset)
      byp_ff |-> s2_valid_ff)
      else $error("line store bypass without an item in flight");

   ap_no_overfill: assert property (@(posedge clock) disable iff (reset)
      accept |=> (q_count < QOW'(MF3_QDEPTH)) || !s2_valid_ff)
      else $error("front accepted an item without queue room");

   ap_bypass_same_col: assert property (@(posedge clock) disable iff (reset)
      byp_ff |-> s2_col_ff == $past(s2_col_ff, 1))
      else $error("bypass taken for a different column");

endmodule

// ----- design/mf3_back.sv -----
// Back end: sliding 3x3 window and pipelined median-of-nine network.
module mf3_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [mf3_pkg::MF3_QCNT_W-1:0]    q_count,
   output logic                              q_pop,
   input  mf3_pkg::mf3_entry_type            q_data,
   input  logic [mf3_pkg::MF3_OCNT_W-1:0]    o_count,
   output logic                              o_push,
   output mf3_pkg::mf3_rsp_type              o_data
);
   import mf3_pkg::*;

   localparam int OW = MF3_OCNT_W + 1;

   mf3_pixel_type win_ff [MF3_WIN_CELLS];
   mf3_pixel_type win_in [MF3_WIN_CELLS];
   mf3_trio_type  trio   [MF3_WIN_DIM];

   logic          s1_valid_ff, s2_valid_ff, s3_valid_ff;
   mf3_trio_type  s1_trio_ff [MF3_WIN_DIM];
   logic [11:0]   s1_row_ff, s2_row_ff, s3_row_ff;
   logic [9:0]    s1_col_ff, s2_col_ff, s3_col_ff;
   logic          s1_fend_ff, s2_fend_ff, s3_fend_ff;
   mf3_pixel_type s2_lo_ff, s2_md_ff, s2_hi_ff, s3_med_ff;

   logic [OW-1:0] occupancy;
   logic          s1_valid_in;

   // Results in the pipeline already own a slot of the output queue.
   assign occupancy = {1'b0, o_count} + OW'(s1_valid_ff) + OW'(s2_valid_ff)
                    + OW'(s3_valid_ff);
   assign q_pop       = (q_count != '0) && (occupancy < OW'(MF3_ODEPTH));
   assign s1_valid_in = q_pop && q_data.emit;

   always_comb begin
      for (int i = 0; i < MF3_WIN_CELLS; i++) begin
         win_in[i] = win_ff[i];
      end
      if (q_pop) begin
         for (int r = 0; r < MF3_WIN_DIM; r++) begin
            for (int c = 0; c < MF3_WIN_DIM - 1; c++) begin
               win_in[r * MF3_WIN_DIM + c] = win_ff[r * MF3_WIN_DIM + c + 1];
            end
         end
         win_in[MF3_WIN_DIM - 1]                     = q_data.up;
         win_in[2 * MF3_WIN_DIM - 1]                 = q_data.mid;
         win_in[MF3_WIN_CELLS - 1]                   = q_data.px;
      end
      for (int r = 0; r < MF3_WIN_DIM; r++) begin
         trio[r] = mf3_sort3(win_in[r * MF3_WIN_DIM], win_in[r * MF3_WIN_DIM + 1],
                             win_in[r * MF3_WIN_DIM + 2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MF3_WIN_CELLS; i++) begin
            win_ff[i] <= '0;
         end
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < MF3_WIN_CELLS; i++) begin
            win_ff[i] <= win_in[i];
         end
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Rows sorted, then max of lows, median of middles, min of highs,
   // and the median of those three is the median of all nine.
   always_ff @(posedge clock) begin
      for (int r = 0; r < MF3_WIN_DIM; r++) begin
         s1_trio_ff[r] <= trio[r];
      end
      s1_row_ff  <= q_data.out_row;
      s1_col_ff  <= q_data.out_col;
      s1_fend_ff <= q_data.frame_end;

      s2_lo_ff   <= mf3_max(mf3_max(s1_trio_ff[0].lo, s1_trio_ff[1].lo), s1_trio_ff[2].lo);
      s2_md_ff   <= mf3_med3(s1_trio_ff[0].md, s1_trio_ff[1].md, s1_trio_ff[2].md);
      s2_hi_ff   <= mf3_min(mf3_min(s1_trio_ff[0].hi, s1_trio_ff[1].hi), s1_trio_ff[2].hi);
      s2_row_ff  <= s1_row_ff;
      s2_col_ff  <= s1_col_ff;
      s2_fend_ff <= s1_fend_ff;

      s3_med_ff  <= mf3_med3(s2_lo_ff, s2_md_ff, s2_hi_ff);
      s3_row_ff  <= s2_row_ff;
      s3_col_ff  <= s2_col_ff;
      s3_fend_ff <= s2_fend_ff;
   end

   assign o_push              = s3_valid_ff;
   assign o_data.median_value = s3_med_ff;
   assign o_data.out_row      = s3_row_ff;
   assign o_data.out_col      = s3_col_ff;
   assign o_data.frame_end    = s3_fend_ff;

endmodule

// ----- design/median_filter_3x3_top.sv -----
// Top level of the 3x3 median filter: front end, item queue, back end, result queue.
//
// Pixels arrive in raster order as transactions on the req_ queue port: a
// transaction completes at a clock edge with req_push high and req_full low.
// Each pixel at (row, col) completes the window centered on (row-1, col-1);
// when that center is an interior pixel, one result transaction carries the
// median of the nine pixels with its row, column and an end-of-frame flag.
// Border pixels produce nothing. A set frame_start restarts the counters.
// Results wait in a queue: rsp_empty low shows the oldest one on rsp_data,
// and rsp_pop takes it. Width and height are written through csr_ while the
// block is idle; they take effect from the next pixel.
// Throughput is one pixel per cycle while req_full stays low. A result becomes
// visible after the line store read, the handoff queue with the row sorts, two
// more compare stages and the result queue write. The line stores are
// single-write, single-read RAMs with registered read data.
// A stalled receiver fills the result queue, then the back end holds, the
// handoff queue fills, and req_full rises; nothing is lost.
// Reset loads width 640 and height 480 and clears counters, window and
// queues; line store contents are not cleared and need no clearing pass.
module median_filter_3x3_top #(
   parameter int MAX_WIDTH = mf3_pkg::MF3_MAX_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  mf3_pkg::mf3_csr_index_type        csr_index,
   input  logic [mf3_pkg::MF3_CSR_W-1:0]     csr_wdata,
   input  logic                              req_push,
   output logic                              req_full,
   input  mf3_pkg::mf3_req_type              req_data,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output mf3_pkg::mf3_rsp_type              rsp_data
);
   import mf3_pkg::*;

   logic                  q_push, q_pop;
   mf3_entry_type         q_wdata, q_rdata;
   logic [MF3_QCNT_W-1:0] q_count;
   logic                  o_push, o_pop;
   mf3_rsp_type           o_wdata;
   logic [MF3_OCNT_W-1:0] o_count;

   mf3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .q_count   (q_count),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   // The handoff queue lets the front end keep taking pixels while the back end waits.
   mf3_fifo #(.WIDTH($bits(mf3_entry_type)), .DEPTH(MF3_QDEPTH)) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .count     (q_count)
   );

   mf3_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_count (q_count),
      .q_pop   (q_pop),
      .q_data  (q_rdata),
      .o_count (o_count),
      .o_push  (o_push),
      .o_data  (o_wdata)
   );

   // The result queue is the skid stage toward the receiver.
   mf3_fifo #(.WIDTH($bits(mf3_rsp_type)), .DEPTH(MF3_ODEPTH)) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (o_push),
      .push_data (o_wdata),
      .pop       (o_pop),
      .pop_data  (rsp_data),
      .count     (o_count)
   );

   assign rsp_empty = (o_count == '0);
   assign o_pop     = rsp_pop && !rsp_empty;

   ap_item_queue_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_count < MF3_QCNT_W'(MF3_QDEPTH))
      else $error("item queue written while full");

   ap_result_queue_room: assert property (@(posedge clock) disable iff (reset)
      o_push |-> o_count < MF3_OCNT_W'(MF3_ODEPTH))
      else $error("result queue written while full");

   ap_item_queue_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_count != '0)
      else $error("item queue read while empty");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the 3x3 median filter top level with its own window predictor.
module tb;
   import mf3_pkg::*;

   // Cycles without any transaction before the run is declared hung. The limit lies
   // well above the longest stall of either side and the settle pause between phases.
   localparam int QUIET_LIMIT  = 2000;
   localparam int SETTLE_TIME  = 20;
   localparam int RANDOM_ITEMS = 750;
   localparam int MEDIAN_RANK  = MF3_WIN_CELLS / 2;

   logic              clock;
   logic              reset = 1'b1;
   logic              csr_we = 1'b0;
   mf3_csr_index_type csr_index = CSR_IMAGE_WIDTH;
   logic [MF3_CSR_W-1:0] csr_wdata = '0;
   logic              req_push = 1'b0;
   logic              req_full;
   mf3_req_type       req_data = '0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   mf3_rsp_type       rsp_data;

   // Pixels waiting to be pushed, and medians the predictor says must come out.
   mf3_req_type pixel_backlog [$];
   mf3_rsp_type pending_medians [$];

   // The predictor's own copy of the registers, line stores, window and counters.
   logic [10:0]   width_reg = 11'd640;
   logic [11:0]   height_reg = 12'd480;
   mf3_pixel_type older_line [MF3_MAX_WIDTH] = '{default: '0};
   mf3_pixel_type newer_line [MF3_MAX_WIDTH] = '{default: '0};
   mf3_pixel_type window_cells [MF3_WIN_CELLS] = '{default: '0};
   int unsigned   col_pos = 0;
   int unsigned   row_pos = 0;

   int          push_gap = 0;
   int          push_calm = 0;
   int          pop_gap = 0;
   int          pop_calm = 0;
   int          quiet_cycles = 0;
   int          pixels_taken = 0;
   int          results_seen = 0;
   int          frames_closed = 0;
   int          mismatches = 0;
   int          register_writes = 0;
   mf3_rsp_type oldest;

   median_filter_3x3_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The width register keeps 11 bits and is saturated to 3..1024 when used.
   function automatic int unsigned width_in_use(input logic [10:0] raw);
      if (raw < MF3_MIN_DIM) return MF3_MIN_DIM;
      if (raw > MF3_MAX_WIDTH) return MF3_MAX_WIDTH;
      return 32'(raw);
   endfunction

   // The height register can never exceed 4095, so only the lower bound applies.
   function automatic int unsigned height_in_use(input logic [11:0] raw);
      if (raw < MF3_MIN_DIM) return MF3_MIN_DIM;
      return 32'(raw);
   endfunction

   // Advances the predictor by one accepted pixel. A pixel at (row, col) completes
   // the window centered on (row-1, col-1); a median is expected only when that
   // center is interior. Pixels outside the frame in use only move the counters.
   function automatic void predict_pixel(input mf3_req_type item);
      int unsigned w_use;
      int unsigned h_use;
      int unsigned col;
      int unsigned row;
      int          below;
      int          at_most;
      mf3_rsp_type res;
      w_use = width_in_use(width_reg);
      h_use = height_in_use(height_reg);
      if (item.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      col = col_pos;
      row = row_pos;
      if (col < w_use && row < h_use) begin
         for (int r = 0; r < MF3_WIN_DIM; r++) begin
            window_cells[MF3_WIN_DIM * r]     = window_cells[MF3_WIN_DIM * r + 1];
            window_cells[MF3_WIN_DIM * r + 1] = window_cells[MF3_WIN_DIM * r + 2];
         end
         window_cells[2] = older_line[col];
         window_cells[5] = newer_line[col];
         window_cells[8] = item.pixel_value;
         older_line[col] = newer_line[col];
         newer_line[col] = item.pixel_value;
         if (col >= 2 && row >= 2) begin
            res = '0;
            // The median is the value whose rank range covers the fifth place.
            for (int k = 0; k < MF3_WIN_CELLS; k++) begin
               below = 0;
               at_most = 0;
               for (int m = 0; m < MF3_WIN_CELLS; m++) begin
                  if (window_cells[m] < window_cells[k]) below++;
                  if (window_cells[m] <= window_cells[k]) at_most++;
               end
               if (below <= MEDIAN_RANK && at_most > MEDIAN_RANK)
                  res.median_value = window_cells[k];
            end
            res.out_row = 12'(row - 1);
            res.out_col = 10'(col - 1);
            res.frame_end = (row == h_use - 1) && (col == w_use - 1);
            pending_medians.push_back(res);
         end
      end
      if (col + 1 >= w_use) begin
         col_pos = 0;
         row_pos = (row + 1 >= h_use) ? 0 : row + 1;
      end else begin
         col_pos = col + 1;
      end
   endfunction

   // Random idle length: mostly none or short, a few long, and now and then a
   // calm stretch of transactions with no idling at all.
   function automatic int idle_length(inout int calm);
      int pick;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      pick = $urandom_range(99);
      if (pick < 2) begin
         calm = $urandom_range(40, 150);
         return 0;
      end
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Pixel values lean toward the extremes and a narrow band so that ties are common.
   function automatic mf3_pixel_type pick_pixel();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return mf3_pixel_type'($urandom_range(120, 127));
         default: return mf3_pixel_type'($urandom);
      endcase
   endfunction

   function automatic void push_pixel(input mf3_pixel_type value, input logic start);
      mf3_req_type item;
      item.pixel_value = value;
      item.frame_start = start;
      pixel_backlog.push_back(item);
   endfunction

   // Queues a run of random pixels. With noise set, a stray frame start may land
   // anywhere inside the run.
   task automatic queue_pixels(input int count, input logic first_start, input bit noise);
      for (int n = 0; n < count; n++)
         push_pixel(pick_pixel(),
                    (n == 0) ? first_start : (noise && $urandom_range(99) < 3));
   endtask

   // Waits until every queued pixel is taken and every median has come out, then
   // lets the pipeline run dry, since trailing pixels may produce no result.
   task automatic drain_and_settle();
      while (pixel_backlog.size() != 0 || req_push || pending_medians.size() != 0)
         @(negedge clock);
      repeat (SETTLE_TIME) @(posedge clock);
   endtask

   task automatic write_register(input mf3_csr_index_type index,
                                 input logic [MF3_CSR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_IMAGE_WIDTH)
         width_reg = value[10:0];
      else
         height_reg = value;
      register_writes++;
   endtask

   function automatic void report_field(input string field, input logic [11:0] want,
                                        input logic [11:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endfunction

   // Pixel driver. A new transaction is offered once the previous one has been
   // taken, after a random gap; push stays high across back-to-back transactions.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || !req_full) begin
         if (push_gap > 0) begin
            push_gap--;
            req_push <= 1'b0;
         end else if (pixel_backlog.size() != 0) begin
            req_data <= pixel_backlog.pop_front();
            req_push <= 1'b1;
            push_gap = idle_length(push_calm);
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Result consumer. After each taken result it may stall for a random time,
   // which backs the block up into req_full.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (!rsp_empty && rsp_pop) pop_gap = idle_length(pop_calm);
         if (pop_gap > 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Monitor. Values are sampled as they stood before the edge, so the accepted
   // pixel is predicted first and any result taken at the same edge is checked
   // against the oldest pending median. The watchdog sits here as well.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            predict_pixel(req_data);
            pixels_taken++;
         end
         if (!rsp_empty && rsp_pop) begin
            results_seen++;
            if (rsp_data.frame_end) frames_closed++;
            if (pending_medians.size() == 0) begin
               mismatches++;
               $display("%0t: result with none pending, expected nothing, actual %p",
                        $time, rsp_data);
            end else begin
               oldest = pending_medians.pop_front();
               if (rsp_data.median_value !== oldest.median_value)
                  report_field("median_value", 12'(oldest.median_value),
                               12'(rsp_data.median_value));
               if (rsp_data.out_row !== oldest.out_row)
                  report_field("out_row", oldest.out_row, rsp_data.out_row);
               if (rsp_data.out_col !== oldest.out_col)
                  report_field("out_col", 12'(oldest.out_col), 12'(rsp_data.out_col));
               if (rsp_data.frame_end !== oldest.frame_end)
                  report_field("frame_end", 12'(oldest.frame_end), 12'(rsp_data.frame_end));
            end
         end
         if ((req_push && !req_full) || (!rsp_empty && rsp_pop)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("%0t: watchdog, no transaction for %0d cycles", $time, QUIET_LIMIT);
               $display("FAILURE");
               $finish;
            end
         end
      end
   end

   // Stimulus. Registers change only while the block is drained. Whenever the
   // width in use may grow, the next pixel carries frame_start so that the line
   // stores are refilled before any window reads them.
   initial begin : stimulus
      int unsigned random_items;
      int unsigned old_width;
      int unsigned w_use;
      int unsigned h_use;
      int unsigned span;
      int unsigned frame_len;
      int          frame_count;
      int          which;
      bit          carry_on;
      bit          well_formed;
      bit          last_broken;
      logic [MF3_CSR_W-1:0] width_raw;
      logic [MF3_CSR_W-1:0] height_raw;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Smallest frame, reached by saturation: bit 11 of the width write is dropped
      // and both registers fall below the minimum. The first frame alternates the
      // pixel extremes; the second follows without frame_start after the wrap.
      write_register(CSR_IMAGE_WIDTH, 12'h800);
      write_register(CSR_IMAGE_HEIGHT, 12'h000);
      for (int n = 0; n < 9; n++) push_pixel((n % 2) ? 8'hFF : 8'h00, n == 0);
      for (int n = 0; n < 9; n++) push_pixel((n % 2) ? 8'(n) : 8'(8'hFF - n), 1'b0);
      queue_pixels(2, 1'b0, 1'b0);
      drain_and_settle();

      // A frame start in the middle of a frame, then three rows and a half.
      write_register(CSR_IMAGE_WIDTH, 12'd6);
      write_register(CSR_IMAGE_HEIGHT, 12'd5);
      queue_pixels(21, 1'b1, 1'b0);
      drain_and_settle();

      // Both registers shrink in mid-frame: the pending column and row now lie
      // outside the frame, so that pixel is dropped and the counters wrap.
      write_register(CSR_IMAGE_WIDTH, 12'd3);
      write_register(CSR_IMAGE_HEIGHT, 12'd3);
      queue_pixels(6, 1'b0, 1'b0);
      drain_and_settle();

      // Widest row, reached by saturating an all-ones write; only its start is sent.
      write_register(CSR_IMAGE_WIDTH, 12'hFFF);
      write_register(CSR_IMAGE_HEIGHT, 12'h002);
      queue_pixels(40, 1'b1, 1'b0);
      drain_and_settle();

      // Tallest frame, carried on from the wide row without a frame start: the
      // pending column lies outside the narrow row, so the next row begins.
      write_register(CSR_IMAGE_WIDTH, 12'd3);
      write_register(CSR_IMAGE_HEIGHT, 12'hFFF);
      queue_pixels(60, 1'b0, 1'b0);
      drain_and_settle();

      // Random phases: a new size, then a few frames, most of them complete.
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         old_width = width_in_use(width_reg);
         case ($urandom_range(19))
            0: begin
               width_raw = 12'($urandom_range(0, 2));
               if ($urandom_range(1)) width_raw[11] = 1'b1;
            end
            1, 2, 3, 4: width_raw = 12'($urandom_range(11, 32));
            5: width_raw = 12'($urandom_range(33, 64));
            default: width_raw = 12'($urandom_range(3, 10));
         endcase
         case ($urandom_range(19))
            0: height_raw = 12'($urandom_range(0, 2));
            1: height_raw = 12'hFFF;
            default: height_raw = 12'($urandom_range(3, 7));
         endcase
         which = $urandom_range(9);
         if (which != 9) write_register(CSR_IMAGE_WIDTH, width_raw);
         if (which != 8) write_register(CSR_IMAGE_HEIGHT, height_raw);
         w_use = width_in_use(width_reg);
         h_use = height_in_use(height_reg);
         carry_on = (w_use <= old_width) && ($urandom_range(3) == 0);
         span = w_use * ((h_use > 8) ? 4 : h_use);
         last_broken = 1'b0;
         frame_count = $urandom_range(1, 3);
         for (int f = 0; f < frame_count; f++) begin
            well_formed = (h_use <= 8) && ($urandom_range(7) != 0);
            frame_len = well_formed ? span : $urandom_range(1, span + w_use);
            queue_pixels(frame_len,
                         (f == 0) ? !carry_on : (last_broken || $urandom_range(1)),
                         !well_formed);
            last_broken = !well_formed;
            random_items += frame_len;
         end
         drain_and_settle();
      end

      $display("Run covered %0d pixel transactions, %0d median results and %0d register writes.",
               pixels_taken, results_seen, register_writes);
      $display("End-of-frame marks seen: %0d; mismatches found: %0d.",
               frames_closed, mismatches);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- files.f -----
design/mf3_pkg.sv
design/mf3_ram.sv
design/mf3_fifo.sv
design/mf3_front.sv
design/mf3_back.sv
design/median_filter_3x3_top.sv
sim/tb.sv
